### hw/rtl/lfo_env_pkg.sv
// ----------------------------------------------------------------------------
// lfo_env_pkg
// Shared types, constants and the sine table entry function for the modulation channel.
// ----------------------------------------------------------------------------
package lfo_env_pkg;

  localparam int SINE_ENTRIES_DEF = 256;
  localparam int MAX_BLOCK_DEF    = 4096;

  localparam logic [2:0] MODE_ENV = 3'd0;
  localparam logic [2:0] MODE_TRI = 3'd1;
  localparam logic [2:0] MODE_SQR = 3'd2;
  localparam logic [2:0] MODE_SIN = 3'd3;
  localparam logic [2:0] MODE_OFF = 3'd4;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_MOD     = 2'd1;
  localparam logic [1:0] KIND_RESTORE = 2'd2;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_LOW     = 3'd1;
  localparam logic [2:0] REG_HIGH    = 3'd2;
  localparam logic [2:0] REG_STEP    = 3'd3;
  localparam logic [2:0] REG_DECAY   = 3'd4;
  localparam logic [2:0] REG_TMIN    = 3'd5;
  localparam logic [2:0] REG_TMAX    = 3'd6;
  localparam logic [2:0] REG_RESTORE = 3'd7;

  // sin(pi/2 * t), Q30 in and out
  function automatic logic [63:0] quarter_sine(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] s;
    t2 = (t * t) >> 30;
    s  = 64'd172272;
    s  = 64'd5026995    - ((t2 * s) >> 30);
    s  = 64'd85569305   - ((t2 * s) >> 30);
    s  = 64'd693598668  - ((t2 * s) >> 30);
    s  = 64'd1686629713 - ((t2 * s) >> 30);
    return (t * s) >> 30;
  endfunction

  // Table entry k of n; evaluated on constant arguments only
  function automatic logic [16:0] sine_entry(input int k, input int n);
    logic [63:0] ang;
    logic [1:0]  quad;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] mag;
    logic signed [63:0] v;
    ang  = ((64'(k)) << 32) / 64'(n);
    quad = ang[31:30];
    x    = {34'd0, ang[29:0]};
    t    = quad[0] ? (64'd1073741824 - x) : x;
    mag  = (quarter_sine(t) * 64'd32768 + 64'd536870912) >> 30;
    v    = quad[1] ? (64'sd32768 - $signed(mag)) : (64'sd32768 + $signed(mag));
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return v[16:0];
  endfunction

endpackage

### hw/rtl/lfo_envelope_modulator.sv
// ----------------------------------------------------------------------------
// lfo_envelope_modulator
// One modulation channel: envelope follower or LFO mapped to a target range.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one transaction per audio block. tdata = input_level[17:0],
//    block_samples[30:18]. m_axis: one transaction per input, tuser =
//    write_kind, tdata = param_value.
//  - APB: registers at 4*i, written while idle; any write rearms the channel
//    (phase and envelope cleared on the next on block).
//  - One shared 33x33 signed multiplier with a result register serves the
//    decay power, envelope update, phase step and range mapping products.
//  - Order: an envelope block runs PSQ, BSQ, ENVW per bit of n (13 bits at
//    most), then PSQ, ENV, ENVW, MAP, MAPW, OUT; an LFO block PHS, PHSW, MAP,
//    MAPW, OUT; an empty or off block goes straight to the output. The next
//    block is taken the cycle after the result leaves; only one is in flight.
//  - The result sits in an output register; while the receiver stalls it is
//    held and no new block is taken.
//  - Reset: registers go to their reset values, phase and envelope to zero,
//    output invalid.
// ----------------------------------------------------------------------------
module lfo_envelope_modulator #(
  parameter int SINE_ENTRIES = lfo_env_pkg::SINE_ENTRIES_DEF,
  parameter int MAX_BLOCK    = lfo_env_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // input_level[17:0], block_samples[30:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // param_value[31:0]
  output logic [1:0]  m_axis_tuser,   // write_kind[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfo_env_pkg::*;

  localparam int SW = $clog2(SINE_ENTRIES);
  localparam logic [16:0] NMAX = 17'(MAX_BLOCK);

  logic [16:0] sine_rom [SINE_ENTRIES];
  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_ENTRIES);
  end

  // registers
  logic [2:0]  source_mode;
  logic [31:0] range_low, range_high, phase_step, target_min, target_max, restore_value;
  logic [15:0] env_decay;

  logic [31:0] phase_accum;
  logic [17:0] env_level;
  logic        was_on, rearm_pending;

  // sequencer
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PSQ   = 4'd1;  // d = d*base
  localparam logic [3:0] ST_BSQ   = 4'd2;  // base = base*base
  localparam logic [3:0] ST_ENV   = 4'd3;  // |diff|*c
  localparam logic [3:0] ST_ENVW  = 4'd4;
  localparam logic [3:0] ST_PHS   = 4'd5;  // step*n
  localparam logic [3:0] ST_PHSW  = 4'd6;
  localparam logic [3:0] ST_MAP   = 4'd7;  // v*(high-low)
  localparam logic [3:0] ST_MAPW  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;

  logic [3:0]  state;
  logic [16:0] nrem;
  logic [17:0] lvl;
  logic [16:0] dval, base;
  logic [16:0] vsrc;
  logic        diff_neg;
  logic [17:0] diff_mag;

  // shared multiplier: 33x33 signed, registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;

  logic signed [32:0] span;
  assign span = 33'(signed'(range_high)) - 33'(signed'(range_low));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_PSQ: begin ma = 33'(dval); mb = 33'(base); end
      ST_BSQ: begin ma = 33'(base); mb = 33'(base); end
      ST_ENV: begin ma = 33'(diff_mag); mb = 33'(17'd65536 - dval); end
      ST_PHS: begin ma = {1'b0, phase_step}; mb = 33'(nrem); end
      ST_MAP: begin ma = 33'(vsrc); mb = span; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= ma * mb;
  end

  logic [16:0] mq16;  // rounded Q16 product for decay power
  logic [47:0] mr;
  assign mr   = mprod[47:0] + 48'd32768;
  assign mq16 = mr[32:16];

  // envelope update from the registered product
  logic [17:0] adj;
  logic signed [19:0] env_new;
  logic [22:0] e33;
  logic [18:0] e33q;
  assign adj = mr[33:16];
  assign env_new = diff_neg ? (20'(env_level) - 20'(adj)) : (20'(env_level) + 20'(adj));

  logic [31:0] pnew;
  assign pnew = phase_accum + mprod[31:0];
  logic [15:0] pp;
  assign pp = pnew[31:16];

  // map result
  logic signed [65:0] mapsum;
  logic signed [31:0] res32;
  logic signed [33:0] res;
  assign mapsum = mprod + 66'sd32768;
  assign res = 34'(signed'(range_low)) + 34'(mapsum >>> 16);

  function automatic logic [31:0] clampv(input logic signed [33:0] x,
                                         input logic [31:0] lo, input logic [31:0] hi);
    if (x < 34'(signed'(lo))) return lo;
    if (x > 34'(signed'(hi))) return hi;
    return x[31:0];
  endfunction

  assign res32 = clampv(res, target_min, target_max);

  logic [17:0] env_clip;
  always_comb begin
    if (env_new < 0) env_clip = '0;
    else if (env_new > 20'sd131071) env_clip = 18'd131071;
    else env_clip = env_new[17:0];
    e33  = 23'(env_clip) * 23'd33;
    // exact /10 via reciprocal, valid for any 32-bit dividend
    e33q = 19'((64'(e33) * 64'd3435973837) >> 35);
  end
  logic [16:0] env_v;
  always_comb begin
    env_v = (e33q > 19'd65536) ? 17'd65536 : e33q[16:0];
  end

  logic [16:0] lfo_v;
  logic [SW-1:0] sidx;
  assign sidx = SW'((64'(pnew) * 64'(SINE_ENTRIES)) >> 32);
  always_comb begin
    case (source_mode)
      MODE_TRI: lfo_v = pp[15] ? 17'(18'd131072 - 18'({pp, 1'b0})) : 17'({pp, 1'b0});
      MODE_SQR: lfo_v = pp[15] ? 17'd0 : 17'd65536;
      default:  lfo_v = sine_rom[sidx];
    endcase
  end

  logic [12:0] in_n;
  logic [17:0] in_lvl;
  assign in_lvl = s_axis_tdata[17:0];
  assign in_n   = s_axis_tdata[30:18];
  logic [16:0] n_clip;
  assign n_clip = (17'(in_n) > NMAX) ? NMAX : 17'(in_n);

  logic [1:0]  okind;
  logic [31:0] oval;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_WAIT);
  assign m_axis_tdata  = oval;
  assign m_axis_tuser  = okind;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[4:2])
      REG_MODE:    prdata = 32'(source_mode);
      REG_LOW:     prdata = range_low;
      REG_HIGH:    prdata = range_high;
      REG_STEP:    prdata = phase_step;
      REG_DECAY:   prdata = 32'(env_decay);
      REG_TMIN:    prdata = target_min;
      REG_TMAX:    prdata = target_max;
      default:     prdata = restore_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      source_mode <= MODE_OFF;
      range_low <= '0;
      range_high <= 32'd65536;
      phase_step <= '0;
      env_decay <= 16'd65508;
      target_min <= 32'h8000_0000;
      target_max <= 32'h7FFF_FFFF;
      restore_value <= '0;
      phase_accum <= '0;
      env_level <= '0;
      was_on <= 1'b0;
      rearm_pending <= 1'b0;
    end else begin
      if (cfg_wr) begin
        rearm_pending <= 1'b1;
        case (paddr[4:2])
          REG_MODE:  source_mode <= pwdata[2:0];
          REG_LOW:   range_low <= pwdata;
          REG_HIGH:  range_high <= pwdata;
          REG_STEP:  phase_step <= pwdata;
          REG_DECAY: env_decay <= pwdata[15:0];
          REG_TMIN:  target_min <= pwdata;
          REG_TMAX:  target_max <= pwdata;
          default:   restore_value <= pwdata;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            okind <= KIND_NONE;
            oval  <= '0;
            nrem  <= n_clip;
            lvl   <= in_lvl[17] ? 18'd0 : in_lvl;
            dval  <= 17'd65536;
            base  <= 17'(env_decay);
            if (in_n == 13'd0) begin
              state <= ST_WAIT;
            end else if (source_mode > MODE_SIN) begin
              if (was_on) begin
                okind  <= KIND_RESTORE;
                oval   <= clampv(34'(signed'(restore_value)), target_min, target_max);
                was_on <= 1'b0;
              end
              state <= ST_WAIT;
            end else begin
              if (rearm_pending) begin
                phase_accum   <= '0;
                env_level     <= '0;
                rearm_pending <= 1'b0;
              end
              state <= (source_mode == MODE_ENV) ? ST_PSQ : ST_PHS;
            end
          end
        end
        ST_PSQ: begin
          if (nrem == 17'd0) begin
            diff_neg <= lvl < env_level;
            diff_mag <= (lvl < env_level) ? env_level - lvl : lvl - env_level;
            state <= ST_ENV;
          end else begin
            state <= ST_BSQ;
          end
        end
        ST_BSQ: begin
          if (nrem[0]) dval <= mq16;
          state <= ST_ENVW;  // reuse as square slot
        end
        ST_ENVW: begin
          if (nrem == 17'd0) begin
            env_level <= env_clip;
            vsrc  <= env_v;
            state <= ST_MAP;
          end else begin
            base  <= mq16;
            nrem  <= nrem >> 1;
            state <= ST_PSQ;
          end
        end
        ST_ENV: begin
          state <= ST_ENVW;
        end
        ST_PHS: state <= ST_PHSW;
        ST_PHSW: begin
          phase_accum <= pnew;
          vsrc  <= lfo_v;
          state <= ST_MAP;
        end
        ST_MAP: state <= ST_MAPW;
        ST_MAPW: begin
          okind  <= KIND_MOD;
          oval   <= res32;
          was_on <= 1'b1;
          state  <= ST_OUT;
        end
        ST_OUT: state <= ST_WAIT;
        ST_WAIT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_NONE) |-> m_axis_tdata == 32'd0)
    else $error("no-write result carries data");
endmodule

### dv/lfo_envelope_modulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_envelope_modulator_test
// Drives audio-block transactions through the modulation channel under random
// idling and backpressure, predicts each result in a scoreboard and compares
// kind and value field by field. Phases reprogram the registers while idle.
// ----------------------------------------------------------------------------
module lfo_envelope_modulator_test;
  import lfo_env_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the registers and channel state,
  // predicts one result per accepted block and checks results in order.
  // --------------------------------------------------------------------------
  class mod_scoreboard;
    logic [2:0]  mode;
    logic [31:0] lo_q, hi_q, step_q, tmin_q, tmax_q, rest_q;
    logic [15:0] decay_q;
    logic [31:0] phase;
    logic [17:0] env;
    bit          on_prev, rearm;
    logic [1:0]  kind_q[$];
    logic [31:0] val_q[$];
    int          errors;

    function void reset_state();
      mode = MODE_OFF; lo_q = 0; hi_q = 32'd65536; step_q = 0; decay_q = 16'd65508;
      tmin_q = 32'h8000_0000; tmax_q = 32'h7fff_ffff; rest_q = 0;
      phase = 0; env = 0; on_prev = 0; rearm = 0; errors = 0;
      kind_q.delete(); val_q.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_MODE:    mode = d[2:0];
        REG_LOW:     lo_q = d;
        REG_HIGH:    hi_q = d;
        REG_STEP:    step_q = d;
        REG_DECAY:   decay_q = d[15:0];
        REG_TMIN:    tmin_q = d;
        REG_TMAX:    tmax_q = d;
        REG_RESTORE: rest_q = d;
        default: ;
      endcase
      rearm = 1;
    endfunction

    function logic [31:0] clamp(longint x);
      longint lo, hi;
      lo = longint'($signed(tmin_q));
      hi = longint'($signed(tmax_q));
      if (x < lo) return tmin_q;
      if (x > hi) return tmax_q;
      return x[31:0];
    endfunction

    function logic [63:0] q30_sine(logic [63:0] t);
      logic [63:0] t2, s;
      t2 = (t * t) >> 30;
      s = 64'd172272;
      s = 64'd5026995 - ((t2 * s) >> 30);
      s = 64'd85569305 - ((t2 * s) >> 30);
      s = 64'd693598668 - ((t2 * s) >> 30);
      s = 64'd1686629713 - ((t2 * s) >> 30);
      return (t * s) >> 30;
    endfunction

    function logic [16:0] sine_at(logic [63:0] k);
      logic [63:0] ang, x, t, mag;
      longint v;
      ang = (k << 32) / SINE_ENTRIES_DEF;
      x = {34'd0, ang[29:0]};
      t = ang[30] ? (64'd1073741824 - x) : x;
      mag = (q30_sine(t) * 64'd32768 + 64'd536870912) >> 30;
      v = ang[31] ? 32768 - longint'(mag) : 32768 + longint'(mag);
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      return v[16:0];
    endfunction

    // Envelope follower: decay power by square-and-multiply, one-pole update
    function logic [16:0] follow(logic [17:0] lvl_bits, int unsigned n);
      logic [63:0] d, base, c, e33;
      longint lvl, e, diff;
      lvl = lvl_bits[17] ? 0 : longint'(lvl_bits);
      d = 65536; base = decay_q;
      while (n != 0) begin
        if (n & 1) d = (d * base + 32768) >> 16;
        base = (base * base + 32768) >> 16;
        n >>= 1;
      end
      c = 65536 - d;
      e = longint'(env);
      diff = lvl - e;
      if (diff >= 0) e += longint'((64'(diff) * c + 32768) >> 16);
      else e -= longint'((64'(-diff) * c + 32768) >> 16);
      if (e < 0) e = 0;
      if (e > 131071) e = 131071;
      env = e[17:0];
      e33 = (64'(env) * 33) / 10;
      return (e33 > 65536) ? 17'd65536 : e33[16:0];
    endfunction

    function logic [16:0] oscillate(int unsigned n);
      logic [15:0] p;
      logic [63:0] prod;
      prod = 64'(step_q) * 64'(n);
      phase = phase + prod[31:0];
      p = phase[31:16];
      if (mode == MODE_TRI) return p[15] ? 17'(18'd131072 - {1'b0, p, 1'b0}) : {p, 1'b0};
      if (mode == MODE_SQR) return p[15] ? 17'd0 : 17'd65536;
      return sine_at((64'(phase) * SINE_ENTRIES_DEF) >> 32);
    endfunction

    function void note_block(logic [17:0] lvl, logic [12:0] cnt);
      int unsigned n;
      logic [16:0] v;
      longint lo, prod, res;
      logic [63:0] sh;
      n = cnt;
      if (n == 0) begin
        kind_q.push_back(KIND_NONE); val_q.push_back(0); return;
      end
      if (n > MAX_BLOCK_DEF) n = MAX_BLOCK_DEF;
      if (mode > MODE_SIN) begin
        if (on_prev) begin
          kind_q.push_back(KIND_RESTORE);
          val_q.push_back(clamp(longint'($signed(rest_q))));
          on_prev = 0;
        end else begin
          kind_q.push_back(KIND_NONE); val_q.push_back(0);
        end
        return;
      end
      if (rearm) begin
        phase = 0; env = 0; rearm = 0;
      end
      v = (mode == MODE_ENV) ? follow(lvl, n) : oscillate(n);
      lo = longint'($signed(lo_q));
      prod = longint'(v) * (longint'($signed(hi_q)) - lo);
      sh = (64'(prod + (longint'(1) << 50)) + 32768) >> 16;
      res = lo + longint'(sh) - (longint'(1) << 34);
      kind_q.push_back(KIND_MOD);
      val_q.push_back(clamp(res));
      on_prev = 1;
    endfunction

    function void check_result(logic [1:0] kind, logic [31:0] val);
      logic [1:0] ek;
      logic [31:0] ev;
      if (kind_q.size() == 0) begin
        $error("unexpected result: write_kind %0d param_value %h", kind, val);
        errors++;
        return;
      end
      ek = kind_q.pop_front();
      ev = val_q.pop_front();
      if (kind !== ek) begin
        $error("write_kind: expected %0d, got %0d", ek, kind); errors++;
      end
      if (val !== ev) begin
        $error("param_value: expected %h, got %h", ev, val); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // input_level[17:0], block_samples[30:18]
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;   // param_value[31:0]
  logic [1:0]  m_axis_tuser;   // write_kind[1:0]
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  mod_scoreboard sb;
  int  cycles;
  int  in_idle_pct, out_idle_pct;  // 0 gives a stretch with no idling
  bit  hold_off;                   // long receiver stall for backpressure

  lfo_envelope_modulator dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit: covers the worst-case block time plus stalls, with margin
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, checked on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // tvalid stays up between back-to-back blocks; drain() drops it
  task automatic send_block(logic [17:0] lvl, logic [12:0] cnt);
    if ($urandom_range(99) < in_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {1'b0, cnt, lvl};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_block(lvl, cnt);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, d);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then the block's own latency
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.kind_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Mostly small blocks, some large, a few oversized or empty
  function automatic logic [12:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return 13'($urandom_range(8191, 4096));
    if (r < 25) return 13'($urandom_range(4096, 1));
    return 13'($urandom_range(64, 1));
  endfunction

  task automatic random_regs();
    write_reg(REG_LOW, $urandom());
    write_reg(REG_HIGH, $urandom());
    write_reg(REG_STEP, ($urandom_range(1)) ? $urandom() : $urandom_range(100000));
    write_reg(REG_DECAY, $urandom_range(65535));
    if ($urandom_range(3) == 0) begin
      write_reg(REG_TMIN, $urandom()); write_reg(REG_TMAX, $urandom());
    end else begin
      write_reg(REG_TMIN, 32'h8000_0000); write_reg(REG_TMAX, 32'h7fff_ffff);
    end
    write_reg(REG_RESTORE, $urandom());
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycles = 0; hold_off = 0; in_idle_pct = 37; out_idle_pct = 37;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: off at reset, zero samples, then each source at the extremes
    send_block(18'h1ffff, 13'd16);
    drain();
    write_reg(REG_MODE, MODE_ENV);
    send_block(18'h1ffff, 13'd1);
    send_block(18'h1ffff, 13'd4096);
    send_block(18'h20000, 13'd8191);      // negative level, oversized block
    send_block(18'h3ffff, 13'd0);         // zero samples does nothing
    drain();
    write_reg(REG_MODE, MODE_OFF);
    send_block(18'h0, 13'd0);             // restore held back by empty block
    send_block(18'h0, 13'd5);             // restore written
    send_block(18'h0, 13'd5);             // already off
    drain();
    write_reg(REG_LOW, 32'h8000_0000);
    write_reg(REG_HIGH, 32'h7fff_ffff);
    write_reg(REG_STEP, 32'hffff_ffff);
    write_reg(REG_DECAY, 16'hffff);
    write_reg(REG_TMIN, 32'h0001_0000);   // inverted target range
    write_reg(REG_TMAX, 32'hffff_0000);
    write_reg(REG_RESTORE, 32'h7fff_ffff);
    for (int m = MODE_TRI; m <= MODE_SIN; m++) begin
      drain();
      write_reg(REG_MODE, 3'(m));
      send_block(18'h0, 13'd1);
      send_block(18'h0, 13'd4095);
      send_block(18'h0, 13'd4096);
    end
    drain();
    write_reg(REG_MODE, 3'd7);            // undefined mode acts as off
    send_block(18'h0, 13'd3);
    send_block(18'h0, 13'd3);
    drain();
    write_reg(REG_DECAY, 16'h0);
    write_reg(REG_TMIN, 32'h8000_0000);
    write_reg(REG_TMAX, 32'h7fff_ffff);
    write_reg(REG_MODE, MODE_ENV);
    send_block(18'h0ffff, 13'd2);

    // Backpressure: receiver stalls long while blocks keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_block(18'($urandom()), 13'($urandom_range(40, 1)));
    join

    // Random phases: new settings each phase, one phase with no idling
    for (int ph = 0; ph < 34; ph++) begin
      drain();
      in_idle_pct  = (ph == 5) ? 0 : 37;
      out_idle_pct = (ph == 5) ? 0 : 37;
      random_regs();
      write_reg(REG_MODE, ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4))
                                                   : 3'($urandom_range(3)));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(19) == 0) begin
          drain();
          write_reg(REG_MODE, 3'($urandom_range(7)));
        end
        send_block(18'($urandom()), rand_count());
      end
    end

    drain();
    if (sb.kind_q.size() == 0 && sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### lfo_envelope_modulator.f
hw/rtl/lfo_env_pkg.sv
hw/rtl/lfo_envelope_modulator.sv
dv/lfo_envelope_modulator_test.sv
